>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers; empty under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define QPMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define QPMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define QPMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define QPMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/qpmm_pkg.sv
`default_nettype none

package qpmm_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int MOTOR_BITS = 12;

  localparam int ANGLE_W  = 16;
  localparam int CMD_W    = 13;
  localparam int GAIN_W   = 16;
  localparam int COEF_W   = GAIN_W + 2;
  localparam int ERR_IN_W = ANGLE_W + 1;
  localparam int ERR_W    = 24;
  localparam int PID_W    = 32;
  localparam int PROD_W   = COEF_W + ERR_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int WIDE_W   = 48;
  localparam int MIX_W    = PID_W + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int THR_BASE  = 4096;
  localparam int THR_SCALE = 1000;
  localparam int THR_SHIFT = 12;

  localparam logic [GAIN_W-1:0]     GAIN_P_RST = 16'd12800;
  localparam logic [GAIN_W-1:0]     GAIN_I_RST = 16'd0;
  localparam logic [GAIN_W-1:0]     GAIN_D_RST = 16'd0;
  localparam logic [MOTOR_BITS-1:0] IDLE_RST   = MOTOR_BITS'(1000);
  localparam logic [MOTOR_BITS-1:0] MAX_RST    = MOTOR_BITS'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_I   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_IDLE_VAL = 3'd3,
    CFG_MAX_VAL  = 3'd4
  } cfg_idx_e;

  // Incremental PID coefficients plus motor limits.
  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [MOTOR_BITS-1:0]    idle_val;
    logic [MOTOR_BITS-1:0]    max_val;
  } cfg_t;

  // adv1: word leaves the input register, adv2: word enters the output register.
  typedef struct packed {
    logic adv1;
    logic idle1;
    logic adv2;
    logic idle2;
    logic clear;
  } pipe_ctrl_t;

  function automatic logic signed [PID_W-1:0] sat_to_32(input logic signed [WIDE_W-1:0] v);
    if (v[WIDE_W-1:PID_W-1] != {(WIDE_W-PID_W+1){v[WIDE_W-1]}}) begin
      return v[WIDE_W-1] ? {1'b1, {(PID_W-1){1'b0}}} : {1'b0, {(PID_W-1){1'b1}}};
    end
    return v[PID_W-1:0];
  endfunction

  function automatic logic signed [ERR_W-1:0] sat_to_24(input logic signed [WIDE_W-1:0] v);
    if (v[WIDE_W-1:ERR_W-1] != {(WIDE_W-ERR_W+1){v[WIDE_W-1]}}) begin
      return v[WIDE_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    end
    return v[ERR_W-1:0];
  endfunction

  // (4096 + cmd) * 1000 / 4096 in Q.FRAC_BITS, from a Q1.12 command, truncated.
  function automatic logic signed [PID_W-1:0] thr_target(input logic [CMD_W-1:0] cmd);
    logic [WIDE_W-1:0] t;
    t = (WIDE_W'(cmd) + WIDE_W'(THR_BASE)) * WIDE_W'(THR_SCALE);
    t = (t << FRAC_BITS) >> THR_SHIFT;
    return t[PID_W-1:0];
  endfunction

  function automatic logic [MOTOR_BITS-1:0] to_motor(input logic signed [MIX_W-1:0] m,
                                                    input logic [MOTOR_BITS-1:0] max_val);
    logic [MIX_W-1:0] v;
    v = MIX_W'(m >>> FRAC_BITS);
    if (m[MIX_W-1]) begin
      return '0;
    end
    if (v > MIX_W'(max_val)) begin
      return max_val;
    end
    return v[MOTOR_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/quad_pid_motor_mixer.sv
// Quad X-frame motor mixer: one sensor word in, four motor compare values out.
// Three stages (input register, PID product register, output register) take a
// new word every cycle while the output is not stalled; under stall the output
// register holds its result and earlier stages fill only their bubbles. The PID
// accumulators and throttle state close through the single accumulate step
// between the product and output registers. Gain writes clear the attitude
// PIDs and base throttle; write configuration only while empty.
`default_nettype none

module quad_pid_motor_mixer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [qpmm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [qpmm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [qpmm_pkg::ANGLE_W-1:0]   measured_roll_i,
  input  logic signed [qpmm_pkg::ANGLE_W-1:0]   measured_pitch_i,
  input  logic signed [qpmm_pkg::ANGLE_W-1:0]   target_roll_i,
  input  logic signed [qpmm_pkg::ANGLE_W-1:0]   target_pitch_i,
  input  logic signed [qpmm_pkg::ANGLE_W-1:0]   target_yaw_rate_i,
  input  logic [qpmm_pkg::CMD_W-1:0]            throttle_command_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [qpmm_pkg::MOTOR_BITS-1:0]       motor_front_left_o,
  output logic [qpmm_pkg::MOTOR_BITS-1:0]       motor_front_right_o,
  output logic [qpmm_pkg::MOTOR_BITS-1:0]       motor_rear_left_o,
  output logic [qpmm_pkg::MOTOR_BITS-1:0]       motor_rear_right_o,
  output logic                                  motors_idle_o
);
  import qpmm_pkg::*;

  cfg_t       cfg;
  logic       gain_wr;
  pipe_ctrl_t ctrl;

  logic v1_q, v2_q, v3_q, idle2_q;
  logic ready1, ready2, ready3, accept;

  logic signed [ANGLE_W-1:0]  mroll_q, mpitch_q, troll_q, tpitch_q, tyaw_q;
  logic [CMD_W-1:0]           cmd_q;
  logic signed [ERR_IN_W-1:0] err_roll, err_pitch, err_yaw;
  logic signed [PID_W-1:0]    pid_roll, pid_pitch, pid_yaw;
  logic [MOTOR_BITS-1:0]      mfl, mfr, mrl, mrr;
  logic [MOTOR_BITS-1:0]      mfl_q, mfr_q, mrl_q, mrr_q;
  logic                       idle_out_q;

  qpmm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .gain_wr_o  (gain_wr)
  );

  // per-stage ready so bubbles drain under output stall
  assign ready3 = !v3_q || !out_stall_i;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;
  assign accept = in_valid_i && ready1;
  assign in_stall_o = !ready1;

  assign ctrl.adv1  = v1_q && ready2;
  assign ctrl.idle1 = (cmd_q == '0);
  assign ctrl.adv2  = v2_q && ready3;
  assign ctrl.idle2 = idle2_q;
  assign ctrl.clear = gain_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      idle2_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (ctrl.adv1) begin
        v1_q <= 1'b0;
      end
      if (ctrl.adv1) begin
        v2_q    <= 1'b1;
        idle2_q <= ctrl.idle1;
      end else if (ctrl.adv2) begin
        v2_q <= 1'b0;
      end
      if (ctrl.adv2) begin
        v3_q <= 1'b1;
      end else if (v3_q && !out_stall_i) begin
        v3_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mroll_q  <= measured_roll_i;
      mpitch_q <= measured_pitch_i;
      troll_q  <= target_roll_i;
      tpitch_q <= target_pitch_i;
      tyaw_q   <= target_yaw_rate_i;
      cmd_q    <= throttle_command_i;
    end
  end

  assign err_roll  = ERR_IN_W'(troll_q) - ERR_IN_W'(mroll_q);
  assign err_pitch = ERR_IN_W'(tpitch_q) - ERR_IN_W'(mpitch_q);
  assign err_yaw   = ERR_IN_W'(tyaw_q);

  qpmm_axis_pid u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg),
    .err_i   (err_roll),
    .pid_d_o (pid_roll)
  );

  qpmm_axis_pid u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg),
    .err_i   (err_pitch),
    .pid_d_o (pid_pitch)
  );

  qpmm_axis_pid u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg),
    .err_i   (err_yaw),
    .pid_d_o (pid_yaw)
  );

  qpmm_lift_mix u_lift (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg),
    .cmd_i      (cmd_q),
    .roll_i     (pid_roll),
    .pitch_i    (pid_pitch),
    .yaw_i      (pid_yaw),
    .motor_fl_o (mfl),
    .motor_fr_o (mfr),
    .motor_rl_o (mrl),
    .motor_rr_o (mrr)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.adv2) begin
      if (idle2_q) begin
        mfl_q <= cfg.idle_val;
        mfr_q <= cfg.idle_val;
        mrl_q <= cfg.idle_val;
        mrr_q <= cfg.idle_val;
      end else begin
        mfl_q <= mfl;
        mfr_q <= mfr;
        mrl_q <= mrl;
        mrr_q <= mrr;
      end
      idle_out_q <= idle2_q;
    end
  end

  assign out_valid_o         = v3_q;
  assign motor_front_left_o  = mfl_q;
  assign motor_front_right_o = mfr_q;
  assign motor_rear_left_o   = mrl_q;
  assign motor_rear_right_o  = mrr_q;
  assign motors_idle_o       = idle_out_q;

endmodule

`default_nettype wire

>>> hw/rtl/qpmm_cfg_regs.sv
`default_nettype none

module qpmm_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qpmm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [qpmm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output qpmm_pkg::cfg_t                  cfg_o,
  output logic                            gain_wr_o
);
  import qpmm_pkg::*;

  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [MOTOR_BITS-1:0]    idle_q, max_q;
  cfg_idx_e                 idx;

  assign idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
      idle_q   <= IDLE_RST;
      max_q    <= MAX_RST;
    end else if (cfg_we_i) begin
      case (idx)
        CFG_GAIN_P:   gain_p_q <= cfg_data_i;
        CFG_GAIN_I:   gain_i_q <= cfg_data_i;
        CFG_GAIN_D:   gain_d_q <= cfg_data_i;
        CFG_IDLE_VAL: idle_q   <= cfg_data_i[MOTOR_BITS-1:0];
        CFG_MAX_VAL:  max_q    <= cfg_data_i[MOTOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign gain_wr_o = cfg_we_i && (idx inside {CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D});

  // a0 = P+I+D, a1 = -(P+2D), a2 = D
  assign cfg_o.a0 = COEF_W'(gain_p_q) + COEF_W'(gain_i_q) + COEF_W'(gain_d_q);
  assign cfg_o.a1 = -(COEF_W'(gain_p_q) + (COEF_W'(gain_d_q) <<< 1));
  assign cfg_o.a2 = COEF_W'(gain_d_q);
  assign cfg_o.idle_val = idle_q;
  assign cfg_o.max_val  = max_q;

endmodule

`default_nettype wire

>>> hw/rtl/qpmm_axis_pid.sv
`default_nettype none

module qpmm_axis_pid (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qpmm_pkg::pipe_ctrl_t                ctrl_i,
  input  qpmm_pkg::cfg_t                      cfg_i,
  input  logic signed [qpmm_pkg::ERR_IN_W-1:0] err_i,
  output logic signed [qpmm_pkg::PID_W-1:0]   pid_d_o
);
  import qpmm_pkg::*;

  logic signed [ERR_W-1:0]  err_cur, err_last_q, err_before_q;
  logic signed [COEF_W-1:0] a0, a1, a2;
  logic signed [PROD_W-1:0] prod0_d, prod1_d, prod2_d;
  logic signed [PROD_W-1:0] prod0_q, prod1_q, prod2_q;
  logic signed [ACC_W-1:0]  acc, incr;
  logic signed [PID_W-1:0]  pid_q;

  // 17-bit error input always fits the 24-bit error range
  assign err_cur = ERR_W'(err_i);
  assign a0 = cfg_i.a0;
  assign a1 = cfg_i.a1;
  assign a2 = cfg_i.a2;

  assign prod0_d = a0 * err_cur;
  assign prod1_d = a1 * err_last_q;
  assign prod2_d = a2 * err_before_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv1) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
      prod2_q <= prod2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_last_q   <= '0;
      err_before_q <= '0;
    end else if (ctrl_i.clear || (ctrl_i.adv1 && ctrl_i.idle1)) begin
      err_last_q   <= '0;
      err_before_q <= '0;
    end else if (ctrl_i.adv1) begin
      err_before_q <= err_last_q;
      err_last_q   <= err_cur;
    end
  end

  // floor shift of the product sum, then saturating accumulate
  assign acc  = ACC_W'(prod0_q) + ACC_W'(prod1_q) + ACC_W'(prod2_q);
  assign incr = acc >>> FRAC_BITS;
  assign pid_d_o = sat_to_32(WIDE_W'(pid_q) + WIDE_W'(incr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q <= '0;
    end else if (ctrl_i.clear || (ctrl_i.adv2 && ctrl_i.idle2)) begin
      pid_q <= '0;
    end else if (ctrl_i.adv2) begin
      pid_q <= pid_d_o;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qpmm_lift_mix.sv
`default_nettype none
`include "assert_macros.svh"

module qpmm_lift_mix (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qpmm_pkg::pipe_ctrl_t                 ctrl_i,
  input  qpmm_pkg::cfg_t                       cfg_i,
  input  logic [qpmm_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [qpmm_pkg::PID_W-1:0]    roll_i,
  input  logic signed [qpmm_pkg::PID_W-1:0]    pitch_i,
  input  logic signed [qpmm_pkg::PID_W-1:0]    yaw_i,
  output logic [qpmm_pkg::MOTOR_BITS-1:0]      motor_fl_o,
  output logic [qpmm_pkg::MOTOR_BITS-1:0]      motor_fr_o,
  output logic [qpmm_pkg::MOTOR_BITS-1:0]      motor_rl_o,
  output logic [qpmm_pkg::MOTOR_BITS-1:0]      motor_rr_o
);
  import qpmm_pkg::*;

  logic signed [PID_W-1:0] target_q;
  logic signed [ERR_W-1:0] lift_last_q, le_d;
  logic signed [PID_W-1:0] lift_out_q, lift_d;
  logic signed [PID_W-1:0] base_q, base_d;
  logic signed [PID_W-1:0] mean_q;
  logic signed [MIX_W-1:0] mix_fl, mix_fr, mix_rl, mix_rr;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv1) begin
      target_q <= thr_target(cmd_i);
    end
  end

  // throttle loop: P=1 incremental form on target minus previous mean
  assign le_d   = sat_to_24(WIDE_W'(target_q) - WIDE_W'(mean_q));
  assign lift_d = sat_to_32(WIDE_W'(lift_out_q) + WIDE_W'(le_d) - WIDE_W'(lift_last_q));
  assign base_d = sat_to_32(WIDE_W'(base_q) + WIDE_W'(lift_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_last_q <= '0;
      lift_out_q  <= '0;
      base_q      <= '0;
      mean_q      <= '0;
    end else begin
      if (ctrl_i.adv2 && ctrl_i.idle2) begin
        lift_last_q <= '0;
        lift_out_q  <= '0;
      end else if (ctrl_i.adv2) begin
        lift_last_q <= le_d;
        lift_out_q  <= lift_d;
      end
      if (ctrl_i.clear || (ctrl_i.adv2 && ctrl_i.idle2)) begin
        base_q <= '0;
      end else if (ctrl_i.adv2) begin
        base_q <= base_d;
      end
      // mean of the unclamped mix is just the base; survives idle and gain writes
      if (ctrl_i.adv2 && !ctrl_i.idle2) begin
        mean_q <= base_d;
      end
    end
  end

  assign mix_fl = MIX_W'(base_d) + MIX_W'(roll_i) - MIX_W'(pitch_i) + MIX_W'(yaw_i);
  assign mix_fr = MIX_W'(base_d) - MIX_W'(roll_i) - MIX_W'(pitch_i) - MIX_W'(yaw_i);
  assign mix_rl = MIX_W'(base_d) + MIX_W'(roll_i) + MIX_W'(pitch_i) - MIX_W'(yaw_i);
  assign mix_rr = MIX_W'(base_d) - MIX_W'(roll_i) + MIX_W'(pitch_i) + MIX_W'(yaw_i);

  assign motor_fl_o = to_motor(mix_fl, cfg_i.max_val);
  assign motor_fr_o = to_motor(mix_fr, cfg_i.max_val);
  assign motor_rl_o = to_motor(mix_rl, cfg_i.max_val);
  assign motor_rr_o = to_motor(mix_rr, cfg_i.max_val);

  `QPMM_ASSERT_NEXT(a_gain_wr_clears_base, clk_i, rst_ni, ctrl_i.clear, base_q == '0)
  `QPMM_ASSERT_NEXT(a_idle_clears_lift, clk_i, rst_ni, ctrl_i.adv2 && ctrl_i.idle2, (lift_out_q == '0) && (lift_last_q == '0) && (base_q == '0))
  `QPMM_ASSERT_NEXT(a_mean_tracks_base, clk_i, rst_ni, ctrl_i.adv2 && !ctrl_i.idle2 && !ctrl_i.clear, mean_q == base_q)

endmodule

`default_nettype wire
